[rtl/ezvad_pkg.sv]
// ezvad_pkg: shared types, widths and register codes for the energy/zcr
// voice activity detector; no dependencies
`timescale 1ns / 1ps

package ezvad_pkg;

    localparam int MAX_FRAME_DEF   = 4096;
    localparam int HIST_DEPTH_DEF  = 10;

    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 31;
    localparam int RATE_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_ENERGY_THR  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ZCR_THR     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SPEECH  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SILENCE = 2'd3;

    localparam logic [ENERGY_W-1:0] ENERGY_THR_RST  = 31'd1000000;
    localparam logic [RATE_W-1:0]   ZCR_THR_RST     = 16'd6554;
    localparam logic [COUNT_W-1:0]  MIN_SPEECH_RST  = 16'd3;
    localparam logic [COUNT_W-1:0]  MIN_SILENCE_RST = 16'd10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_last;
    } sample_beat_t;

    typedef struct packed {
        logic                voice_active;
        logic                raw_voiced;
        logic [ENERGY_W-1:0] frame_energy;
        logic [RATE_W-1:0]   crossing_rate;
    } result_beat_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy_floor;
        logic [RATE_W-1:0]   zcr_threshold;
        logic [COUNT_W-1:0]  min_speech_count;
        logic [COUNT_W-1:0]  min_silence_count;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic acc_en;
        logic frame_clear;
        logic div_start;
        logic div_sel_rate;
        logic cap_energy;
        logic cap_rate;
        logic hist_update;
        logic decide;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic span_zero;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/energy_zcr_voice_activity_detector.sv]
// energy_zcr_voice_activity_detector: top level, config registers, controller, datapath
// samples are taken one per cycle within a frame; a frame end holds the input while
// the one-bit-per-cycle shared divider finds the mean energy and, for frames of more
// than one sample, the crossing rate; the result beat then follows the history and
// decide steps, later only while the previous result beat is still unread
// rst_n clears config to defaults, frame sums, history ring and hangover state
`timescale 1ns / 1ps

module energy_zcr_voice_activity_detector #(
    parameter int MAX_FRAME     = ezvad_pkg::MAX_FRAME_DEF,
    parameter int HISTORY_DEPTH = ezvad_pkg::HIST_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  ezvad_pkg::sample_beat_t           sample_beat,
    // result channel
    output logic                              result_valid,
    input  logic                              result_ready,
    output ezvad_pkg::result_beat_t           result_beat,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ezvad_pkg::PADDR_W-1:0]     paddr,
    input  logic [ezvad_pkg::PDATA_W-1:0]     pwdata,
    output logic [ezvad_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    // configuration registers, one word each at byte offset 4*index
    ezvad_pkg::cfg_t                      cfg_reg;
    logic                                 wr_en;
    logic [ezvad_pkg::REG_IDX_W-1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ezvad_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_floor      <= ezvad_pkg::ENERGY_THR_RST;
            cfg_reg.zcr_threshold     <= ezvad_pkg::ZCR_THR_RST;
            cfg_reg.min_speech_count  <= ezvad_pkg::MIN_SPEECH_RST;
            cfg_reg.min_silence_count <= ezvad_pkg::MIN_SILENCE_RST;
        end
        else if (wr_en)
        begin
            // upper data bits beyond each field are dropped
            unique case (reg_idx)
                ezvad_pkg::REG_ENERGY_THR:
                    cfg_reg.energy_floor      <= pwdata[ezvad_pkg::ENERGY_W-1:0];
                ezvad_pkg::REG_ZCR_THR:
                    cfg_reg.zcr_threshold     <= pwdata[ezvad_pkg::RATE_W-1:0];
                ezvad_pkg::REG_MIN_SPEECH:
                    cfg_reg.min_speech_count  <= pwdata[ezvad_pkg::COUNT_W-1:0];
                ezvad_pkg::REG_MIN_SILENCE:
                    cfg_reg.min_silence_count <= pwdata[ezvad_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        unique case (reg_idx)
            ezvad_pkg::REG_ENERGY_THR:
                prdata = ezvad_pkg::PDATA_W'(cfg_reg.energy_floor);
            ezvad_pkg::REG_ZCR_THR:
                prdata = ezvad_pkg::PDATA_W'(cfg_reg.zcr_threshold);
            ezvad_pkg::REG_MIN_SPEECH:
                prdata = ezvad_pkg::PDATA_W'(cfg_reg.min_speech_count);
            ezvad_pkg::REG_MIN_SILENCE:
                prdata = ezvad_pkg::PDATA_W'(cfg_reg.min_silence_count);
            default:
                prdata = '0;
        endcase
    end

    // controller and datapath talk only through the command and status structs
    ezvad_pkg::dp_cmd_t cmd;
    ezvad_pkg::dp_sts_t sts;

    ezvad_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .frame_last   (sample_beat.frame_last),
        .sample_ready (sample_ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    // accumulators run per sample beat; the result register lets the next
    // frame start while a finished result beat waits downstream
    ezvad_dp #(
        .MAX_FRAME     (MAX_FRAME),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sample_beat  (sample_beat),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

endmodule

[rtl/ezvad_div.sv]
// ezvad_div: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
`timescale 1ns / 1ps

module ezvad_div #(
    parameter int DVD_W = 43,
    parameter int DVS_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/ezvad_dp.sv]
// ezvad_dp: frame accumulators, shared divider, energy history, decision and
// result register; depends on ezvad_pkg and ezvad_div
`timescale 1ns / 1ps

module ezvad_dp #(
    parameter int MAX_FRAME     = ezvad_pkg::MAX_FRAME_DEF,
    parameter int HISTORY_DEPTH = ezvad_pkg::HIST_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ezvad_pkg::dp_cmd_t      cmd,
    output ezvad_pkg::dp_sts_t      sts,
    input  ezvad_pkg::sample_beat_t sample_beat,
    input  ezvad_pkg::cfg_t         cfg,
    output logic                    result_valid,
    input  logic                    result_ready,
    output ezvad_pkg::result_beat_t result_beat
);

    localparam int SW     = ezvad_pkg::SAMPLE_W;
    localparam int EW     = ezvad_pkg::ENERGY_W;
    localparam int RW     = ezvad_pkg::RATE_W;
    localparam int CW     = ezvad_pkg::COUNT_W;
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int CC_W   = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int SUM_W  = 2 * SW - 2 + CNT_W;
    localparam int RD_W   = CC_W + RW;
    localparam int DIV_W  = (SUM_W > RD_W) ? SUM_W : RD_W;
    localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int TOT_W  = EW + $clog2(HISTORY_DEPTH + 1);
    localparam int MUL_W  = TOT_W + 8;
    localparam int ZCMP_W = RW + CNT_W;
    localparam int QCMP_W = CNT_W + 3;

    // frame accumulators
    logic [SUM_W-1:0] sum_reg;
    logic [CC_W-1:0]  cc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             prev_neg_reg;

    logic [SW-1:0]    raw;
    logic             neg;
    logic [SW-1:0]    mag;
    logic [2*SW-1:0]  sq;
    logic [CNT_W-1:0] span;

    assign raw  = sample_beat.sample;
    assign neg  = raw[SW-1];
    assign mag  = neg ? (~raw + 1'b1) : raw;
    assign sq   = mag * mag;
    assign span = cnt_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            cc_reg       <= '0;
            cnt_reg      <= '0;
            prev_neg_reg <= 1'b0;
        end
        else if (cmd.frame_clear)
        begin
            sum_reg      <= '0;
            cc_reg       <= '0;
            cnt_reg      <= '0;
            prev_neg_reg <= 1'b0;
        end
        else if (cmd.acc_en && (cnt_reg < CNT_W'(MAX_FRAME)))
        begin
            sum_reg <= sum_reg + SUM_W'(sq);
            if ((cnt_reg != '0) && (neg != prev_neg_reg))
            begin
                cc_reg <= cc_reg + 1'b1;
            end
            prev_neg_reg <= neg;
            cnt_reg      <= cnt_reg + 1'b1;
        end
    end

    // shared divider: mean energy first, then crossing rate unless the frame has one sample
    logic [DIV_W-1:0] div_dvd;
    logic [CNT_W-1:0] div_dvs;
    logic [DIV_W-1:0] div_quo;
    logic             div_busy;
    logic             div_done;

    assign div_dvd = cmd.div_sel_rate ? DIV_W'({cc_reg, {RW{1'b0}}}) : DIV_W'(sum_reg);
    assign div_dvs = cmd.div_sel_rate ? span : cnt_reg;

    ezvad_div #(
        .DVD_W (DIV_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [EW-1:0] energy_reg;
    logic [RW-1:0] rate_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_energy)
        begin
            energy_reg <= div_quo[EW-1:0];
        end
        if (cmd.cap_rate)
        begin
            if (span == '0)
            begin
                rate_reg <= '0;
            end
            else if (|div_quo[DIV_W-1:RW])
            begin
                rate_reg <= '1;
            end
            else
            begin
                rate_reg <= div_quo[RW-1:0];
            end
        end
    end

    // energy history ring, entries read as zero until first written
    logic [EW-1:0]            hist_mem [HISTORY_DEPTH];
    logic [EW-1:0]            hist_rd_reg;
    logic [HISTORY_DEPTH-1:0] hist_vld_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [TOT_W-1:0]         total_reg;
    logic [EW-1:0]            hist_old;

    assign hist_old = hist_vld_reg[ptr_reg] ? hist_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        hist_rd_reg <= hist_mem[ptr_reg];
        if (cmd.hist_update)
        begin
            hist_mem[ptr_reg] <= energy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            ptr_reg      <= '0;
            total_reg    <= '0;
        end
        else if (cmd.hist_update)
        begin
            hist_vld_reg[ptr_reg] <= 1'b1;
            ptr_reg   <= (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            total_reg <= total_reg - TOT_W'(hist_old) + TOT_W'(energy_reg);
        end
    end

    // partial checks, registered alongside the history update
    logic             above_thr_reg;
    logic             rate_lo_reg;
    logic             rate_hi_reg;
    logic [ZCMP_W-1:0] zcr_prod;
    logic [ZCMP_W-1:0] cc_shift;
    logic [QCMP_W-1:0] cc_x5;
    logic [QCMP_W-1:0] span_x4;

    assign zcr_prod = cfg.zcr_threshold * span;
    assign cc_shift = ZCMP_W'({cc_reg, {RW{1'b0}}});
    assign cc_x5    = QCMP_W'(cc_reg) + (QCMP_W'(cc_reg) << 2);
    assign span_x4  = QCMP_W'(span) << 2;

    always_ff @(posedge clk)
    begin
        if (cmd.hist_update)
        begin
            above_thr_reg <= energy_reg > cfg.energy_floor;
            rate_lo_reg   <= cc_shift > zcr_prod;
            rate_hi_reg   <= cc_x5 < span_x4;
        end
    end

    // decision and hangover counters
    logic [MUL_W-1:0] e_scaled;
    logic [MUL_W-1:0] t_scaled;
    logic             voiced;
    logic [CW-1:0]    speech_reg, speech_new;
    logic [CW-1:0]    silence_reg, silence_new;
    logic             active_reg, active_new;
    logic             voiced_reg;

    assign e_scaled = MUL_W'(2 * HISTORY_DEPTH) * MUL_W'(energy_reg);
    assign t_scaled = MUL_W'(total_reg) + (MUL_W'(total_reg) << 1);
    assign voiced   = above_thr_reg && (e_scaled > t_scaled) && rate_lo_reg && rate_hi_reg;

    always_comb
    begin
        if (voiced)
        begin
            speech_new  = (speech_reg == '1) ? speech_reg : speech_reg + 1'b1;
            silence_new = '0;
            active_new  = (speech_new >= cfg.min_speech_count) ? 1'b1 : active_reg;
        end
        else
        begin
            speech_new  = '0;
            silence_new = (silence_reg == '1) ? silence_reg : silence_reg + 1'b1;
            active_new  = (silence_new >= cfg.min_silence_count) ? 1'b0 : active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speech_reg  <= '0;
            silence_reg <= '0;
            active_reg  <= 1'b0;
            voiced_reg  <= 1'b0;
        end
        else if (cmd.decide)
        begin
            speech_reg  <= speech_new;
            silence_reg <= silence_new;
            active_reg  <= active_new;
            voiced_reg  <= voiced;
        end
    end

    // result register
    logic                    out_vld_reg;
    ezvad_pkg::result_beat_t out_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_beat_reg.voice_active  <= active_reg;
            out_beat_reg.raw_voiced    <= voiced_reg;
            out_beat_reg.frame_energy  <= energy_reg;
            out_beat_reg.crossing_rate <= rate_reg;
        end
    end

    assign result_valid = out_vld_reg;
    assign result_beat  = out_beat_reg;

    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;
    assign sts.span_zero = (span == '0);
    assign sts.out_free  = !out_vld_reg || result_ready;

endmodule

[rtl/ezvad_ctrl.sv]
// ezvad_ctrl: sequencer for accumulate, divide, history, decide and result
// load; depends on ezvad_pkg
`timescale 1ns / 1ps

module ezvad_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    input  logic               frame_last,
    output logic               sample_ready,
    output ezvad_pkg::dp_cmd_t cmd,
    input  ezvad_pkg::dp_sts_t sts
);

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_GO    = 3'd1;
    localparam logic [2:0] S_DIV_E = 3'd2;
    localparam logic [2:0] S_DIV_R = 3'd3;
    localparam logic [2:0] S_HIST  = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        unique case (state_reg)
            S_ACC:
            begin
                sample_ready = 1'b1;
                cmd.acc_en   = sample_valid;
                if (sample_valid && frame_last)
                begin
                    state_next = S_GO;
                end
            end
            S_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_E;
            end
            S_DIV_E:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_energy = 1'b1;
                    if (sts.span_zero)
                    begin
                        cmd.cap_rate = 1'b1;
                        state_next   = S_HIST;
                    end
                    else
                    begin
                        cmd.div_start    = 1'b1;
                        cmd.div_sel_rate = 1'b1;
                        state_next       = S_DIV_R;
                    end
                end
            end
            S_DIV_R:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_rate = 1'b1;
                    state_next   = S_HIST;
                end
            end
            S_HIST:
            begin
                cmd.hist_update = 1'b1;
                state_next      = S_DEC;
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out    = 1'b1;
                    cmd.frame_clear = 1'b1;
                    state_next      = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready && frame_last) |=> !sample_ready)
        else $error("input still open after frame end");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_DIV_E || state_reg == S_DIV_R))
        else $error("divider done outside a divide state");
`endif

endmodule
